// File: rtl/nls_pkg.sv
// ----------------------------------------------------------------------------
// N50 length statistics package
// Shared sizes, word types and the control group of the sorting cells.
// ----------------------------------------------------------------------------
package nls_pkg;

    // Storage capacity and the width of one stored length.
    localparam int MAX_READS   = 1024;
    localparam int LENGTH_BITS = 24;

    // Derived internal widths.
    localparam int CNT_W      = $clog2(MAX_READS + 1);
    localparam int SUM_W      = LENGTH_BITS + $clog2(MAX_READS);
    localparam int DIVIDEND_W = SUM_W + 1;

    // Fixed widths of the port fields.
    localparam int LEN_FW   = 24;
    localparam int TOTAL_FW = 34;
    localparam int COUNT_FW = 11;

    typedef struct packed {
        logic [LEN_FW-1:0] read_length;
        logic              is_last;
    } nls_in_t;

    typedef struct packed {
        logic [TOTAL_FW-1:0] total_bases;
        logic [COUNT_FW-1:0] read_count;
        logic [LEN_FW-1:0]   avg_length;
        logic [LEN_FW-1:0]   longest_length;
        logic [LEN_FW-1:0]   n50_length;
        logic [COUNT_FW-1:0] n50_index;
        logic                overflowed;
    } nls_out_t;

    // A length travelling from one cell to the next.
    typedef struct packed {
        logic                   valid;
        logic [LENGTH_BITS-1:0] value;
    } nls_pass_t;

    // Broadcast control for the whole row of cells.
    typedef struct packed {
        logic shift;
        logic clear;
    } nls_cell_ctrl_t;

endpackage

// File: rtl/nls_cell.sv
// ----------------------------------------------------------------------------
// N50 sorting cell
// One cell of the systolic insertion sorter; keeps the larger length.
// ----------------------------------------------------------------------------
module nls_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nls_pkg::nls_cell_ctrl_t        ctrl,
    input  nls_pkg::nls_pass_t             pass_in,
    input  logic [nls_pkg::LENGTH_BITS-1:0] right_value,
    output nls_pkg::nls_pass_t             pass_out,
    output logic [nls_pkg::LENGTH_BITS-1:0] value
);

    logic [nls_pkg::LENGTH_BITS-1:0] value_reg;
    logic [nls_pkg::LENGTH_BITS-1:0] value_next;
    logic                            occ_reg;
    logic                            occ_next;
    logic                            pass_valid_reg;
    logic [nls_pkg::LENGTH_BITS-1:0] pass_value_reg;
    nls_pkg::nls_pass_t              pass_next;

    // An empty cell absorbs the arriving length; a full one keeps the
    // larger of the two and hands the smaller one on.
    always_comb
    begin
        value_next       = value_reg;
        occ_next         = occ_reg;
        pass_next.valid  = 1'b0;
        pass_next.value  = pass_in.value;
        if (ctrl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            value_next = right_value;
        end
        else if (pass_in.valid)
        begin
            if (!occ_reg)
            begin
                value_next = pass_in.value;
                occ_next   = 1'b1;
            end
            else if (pass_in.value > value_reg)
            begin
                value_next      = pass_in.value;
                pass_next.valid = 1'b1;
                pass_next.value = value_reg;
            end
            else
            begin
                pass_next.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg        <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg        <= occ_next;
            pass_valid_reg <= pass_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        pass_value_reg <= pass_next.value;
    end

    assign pass_out = {pass_valid_reg, pass_value_reg};
    assign value    = value_reg;

endmodule

// File: rtl/nls_div.sv
// ----------------------------------------------------------------------------
// N50 mean divider
// Restoring divider giving one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nls_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [nls_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [nls_pkg::CNT_W-1:0]       divisor,
    output logic                            done,
    output logic [nls_pkg::DIVIDEND_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(nls_pkg::DIVIDEND_W + 1);

    logic [nls_pkg::DIVIDEND_W-1:0] quo_reg;
    logic [nls_pkg::DIVIDEND_W-1:0] quo_next;
    logic [nls_pkg::CNT_W-1:0]      rem_reg;
    logic [nls_pkg::CNT_W-1:0]      rem_next;
    logic [nls_pkg::CNT_W-1:0]      dsr_reg;
    logic [nls_pkg::CNT_W-1:0]      dsr_next;
    logic [STEP_W-1:0]              step_reg;
    logic [STEP_W-1:0]              step_next;
    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    logic [nls_pkg::CNT_W:0]        trial;
    logic [nls_pkg::CNT_W:0]        diff;

    // The dividend shifts out at the top while quotient bits enter below.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[nls_pkg::DIVIDEND_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[nls_pkg::CNT_W-1:0];
                quo_next = {quo_reg[nls_pkg::DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[nls_pkg::CNT_W-1:0];
                quo_next = {quo_reg[nls_pkg::DIVIDEND_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(nls_pkg::DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/n50_length_statistics_core.sv
// ----------------------------------------------------------------------------
// N50 length statistics core
// Collects read lengths, sorts them in a systolic cell row and reports the
// total, count, rounded mean, longest length and the N50 length and rank.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                 | Word
//  ---------+---------------------------+-------------------------------
//  read     | read_valid / read_ready   | read_data  (nls_in_t)
//  stats    | stats_valid / stats_ready | stats_data (nls_out_t)
//
// While a set is loading, one word is taken in every cycle; each length
// enters the first sorting cell and ripples down the row one cell a cycle.
// After the marked last word the block stops taking words while the row
// settles, then while the sorted row shifts past the running sum, and until
// the result is written. The rounded mean comes from a one-bit-per-cycle
// divider that runs beside the settling and scan; the result is written
// only once the divider is done.
// Reset empties every cell and the control state at once; no sweep is needed.
// A finished result waits in the output register; the next set may load
// meanwhile, and only its own result waits for the previous one to be taken.
//
module n50_length_statistics_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               read_valid,
    output logic               read_ready,
    input  nls_pkg::nls_in_t   read_data,
    output logic               stats_valid,
    input  logic               stats_ready,
    output nls_pkg::nls_out_t  stats_data
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_SCAN,
        ST_FINISH
    } state_t;

    localparam int CW = nls_pkg::CNT_W;
    localparam int SW = nls_pkg::SUM_W;
    localparam int LW = nls_pkg::LENGTH_BITS;

    state_t                state_reg, state_next;

    // Running totals of the set that is loading.
    logic [CW-1:0]         count_reg, count_next;
    logic [SW-1:0]         total_reg, total_next;
    logic                  ovf_reg, ovf_next;

    // Snapshot of the finished set while it is settled and scanned.
    logic [CW-1:0]         n_reg, n_next;
    logic [SW-1:0]         sum_reg, sum_next;
    logic                  ovf_snap_reg, ovf_snap_next;

    logic [CW-1:0]         timer_reg, timer_next;
    logic [SW-1:0]         cum_reg, cum_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [LW-1:0]         longest_reg, longest_next;
    logic [LW-1:0]         n50_len_reg, n50_len_next;
    logic [CW-1:0]         n50_idx_reg, n50_idx_next;

    nls_pkg::nls_out_t     out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  accept;
    logic                  has_room;
    logic [LW-1:0]         in_len;
    logic [SW-1:0]         cum_sum;
    logic [SW:0]           cum_twice;
    logic                  crossed;
    logic                  last_read;
    logic                  div_start;
    logic                  div_done;
    logic [nls_pkg::DIVIDEND_W-1:0] div_dividend;
    logic [nls_pkg::DIVIDEND_W-1:0] div_quotient;

    nls_pkg::nls_cell_ctrl_t cell_ctrl;
    nls_pkg::nls_pass_t      cell_pass  [nls_pkg::MAX_READS+1];
    logic [LW-1:0]           cell_value [nls_pkg::MAX_READS];

    assign read_ready = (state_reg == ST_LOAD);
    assign accept     = read_valid && read_ready;
    assign has_room   = (count_reg < CW'(nls_pkg::MAX_READS));
    assign in_len     = read_data.read_length[LW-1:0];

    // A length enters the first cell only if the store still has room;
    // otherwise it is dropped and the overflow flag is raised.
    assign cell_pass[0] = {accept && has_room, in_len};

    // The row of sorting cells: each one keeps the larger length and hands
    // the smaller one to its right neighbour. During the scan the row shifts
    // left so that the sorted lengths leave the first cell in descending order.
    for (genvar g = 0; g < nls_pkg::MAX_READS; g++)
    begin : g_cell
        logic [LW-1:0] right_value;
        if (g == nls_pkg::MAX_READS - 1)
        begin : g_end
            assign right_value = '0;
        end
        else
        begin : g_mid
            assign right_value = cell_value[g+1];
        end

        nls_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .pass_in     (cell_pass[g]),
            .right_value (right_value),
            .pass_out    (cell_pass[g+1]),
            .value       (cell_value[g])
        );
    end

    // The mean is (total + n/2) / n, which rounds ties upward.
    assign div_start    = (state_reg == ST_DRAIN) && (timer_reg == '0);
    assign div_dividend = nls_pkg::DIVIDEND_W'(sum_reg)
                        + nls_pkg::DIVIDEND_W'(n_reg >> 1);

    nls_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // The half-total test compares twice the running sum with the total,
    // so it stays exact without any fraction.
    assign cum_sum   = cum_reg + SW'(cell_value[0]);
    assign cum_twice = {cum_sum, 1'b0};
    assign crossed   = cum_twice > {1'b0, sum_reg};
    assign last_read = (idx_reg + CW'(1)) == n_reg;

    assign cell_ctrl.shift = (state_reg == ST_SCAN);
    assign cell_ctrl.clear = (state_next == ST_LOAD) && (state_reg == ST_FINISH);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        sum_next       = sum_reg;
        ovf_snap_next  = ovf_snap_reg;
        timer_next     = timer_reg;
        cum_next       = cum_reg;
        idx_next       = idx_reg;
        longest_next   = longest_reg;
        n50_len_next   = n50_len_reg;
        n50_idx_next   = n50_idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && stats_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CW'(1);
                        total_next = total_reg + SW'(in_len);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (read_data.is_last)
                    begin
                        n_next        = count_next;
                        sum_next      = total_next;
                        ovf_snap_next = ovf_next;
                        count_next    = '0;
                        total_next    = '0;
                        ovf_next      = 1'b0;
                        timer_next    = '0;
                        state_next    = ST_DRAIN;
                    end
                end
            end

            ST_DRAIN:
            begin
                // The row is left to settle until every ripple has come to rest.
                timer_next = timer_reg + CW'(1);
                if (timer_reg == n_reg - CW'(1))
                begin
                    cum_next   = '0;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    longest_next = cell_value[0];
                end
                cum_next = cum_sum;
                idx_next = idx_reg + CW'(1);
                // If no read passes half the total (all lengths zero), the
                // scan ends on the last, smallest read.
                if (crossed || last_read)
                begin
                    n50_len_next = cell_value[0];
                    n50_idx_next = idx_reg + CW'(1);
                    state_next   = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (div_done && !out_valid_next)
                begin
                    out_next.total_bases    = nls_pkg::TOTAL_FW'(sum_reg);
                    out_next.read_count     = nls_pkg::COUNT_FW'(n_reg);
                    out_next.avg_length     = nls_pkg::LEN_FW'(div_quotient);
                    out_next.longest_length = nls_pkg::LEN_FW'(longest_reg);
                    out_next.n50_length     = nls_pkg::LEN_FW'(n50_len_reg);
                    out_next.n50_index      = nls_pkg::COUNT_FW'(n50_idx_reg);
                    out_next.overflowed     = ovf_snap_reg;
                    out_valid_next          = 1'b1;
                    state_next              = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= '0;
            sum_reg       <= '0;
            ovf_snap_reg  <= 1'b0;
            timer_reg     <= '0;
            cum_reg       <= '0;
            idx_reg       <= '0;
            longest_reg   <= '0;
            n50_len_reg   <= '0;
            n50_idx_reg   <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            n_reg         <= n_next;
            sum_reg       <= sum_next;
            ovf_snap_reg  <= ovf_snap_next;
            timer_reg     <= timer_next;
            cum_reg       <= cum_next;
            idx_reg       <= idx_next;
            longest_reg   <= longest_next;
            n50_len_reg   <= n50_len_next;
            n50_idx_reg   <= n50_idx_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stats_valid = out_valid_reg;
    assign stats_data  = out_reg;

endmodule
